// ----- hdl/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue core.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps

package mhpq_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = IDX_W + 2;
	localparam int OCC_W    = 8;
	localparam int STAT_W   = 2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_EXTRACTED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam logic MODE_EXTRACT = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_UP_RD,
		DP_UP_STEP,
		DP_DN_RD0,
		DP_DN_INIT,
		DP_DN_RD,
		DP_DN_STEP,
		DP_PLACE,
		DP_OUT
	} dp_cmd_t;

	typedef struct packed {
		logic start_up;
		logic start_dn;
		logic at_root;
		logic up_less;
		logic no_child;
		logic dn_less;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD0,
		S_DN_INIT,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} ctl_state_t;

endpackage

// ----- hdl/mhpq_datapath.sv -----
// Heap datapath: key store memory, moving key, index, count and result registers.
// Depends on mhpq_pkg; driven by mhpq_ctrl commands.
`timescale 1ns / 1ps

module mhpq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mhpq_pkg::dp_cmd_t              cmd,
	output mhpq_pkg::dp_stat_t             stat,
	input  logic                           in_mode,
	input  mhpq_pkg::key_t                 in_key,
	output logic [mhpq_pkg::STAT_W-1:0]    out_status,
	output mhpq_pkg::key_t                 out_key,
	output logic [mhpq_pkg::OCC_W-1:0]     out_occ
);

	mhpq_pkg::key_t mem [mhpq_pkg::CAPACITY];

	mhpq_pkg::key_t    key_q;
	mhpq_pkg::key_t    res_key_q;
	mhpq_pkg::idx_t    idx_q;
	mhpq_pkg::cnt_t    count_q;
	mhpq_pkg::status_t status_q;
	mhpq_pkg::key_t    rd0_q;
	mhpq_pkg::key_t    rd1_q;

	mhpq_pkg::idx_t rd_addr0, rd_addr1, wr_addr, parent, last_idx;
	mhpq_pkg::key_t wr_data, child_key;
	mhpq_pkg::cnt_t count_m1;
	logic           wr_en, full, empty, use_r;
	logic [mhpq_pkg::CH_W-1:0] l_ch, r_ch, n_ch;

	assign full     = (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign parent   = (idx_q - 1'b1) >> 1;
	assign count_m1 = count_q - 1'b1;
	assign last_idx = count_m1[mhpq_pkg::IDX_W-1:0];
	assign l_ch     = mhpq_pkg::CH_W'({idx_q, 1'b1});
	assign r_ch     = l_ch + 1'b1;
	assign n_ch     = mhpq_pkg::CH_W'(count_q);
	// right child only counts when it exists; tie picks left
	assign use_r     = (r_ch < n_ch) && (rd1_q < rd0_q);
	assign child_key = use_r ? rd1_q : rd0_q;

	assign stat.start_up = (in_mode != mhpq_pkg::MODE_EXTRACT) && !full;
	assign stat.start_dn = (in_mode == mhpq_pkg::MODE_EXTRACT) && !empty;
	assign stat.at_root  = (idx_q == '0);
	assign stat.up_less  = key_q < rd0_q;
	assign stat.no_child = l_ch >= n_ch;
	assign stat.dn_less  = child_key < key_q;

	always_comb begin
		rd_addr0 = '0;
		rd_addr1 = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = key_q;
		case (cmd)
			mhpq_pkg::DP_UP_RD: rd_addr0 = parent;
			mhpq_pkg::DP_UP_STEP: begin
				wr_en   = 1'b1;
				wr_data = stat.up_less ? rd0_q : key_q;
			end
			mhpq_pkg::DP_DN_RD0: rd_addr1 = last_idx;
			mhpq_pkg::DP_DN_RD: begin
				rd_addr0 = l_ch[mhpq_pkg::IDX_W-1:0];
				rd_addr1 = r_ch[mhpq_pkg::IDX_W-1:0];
			end
			mhpq_pkg::DP_DN_STEP: begin
				wr_en   = 1'b1;
				wr_data = stat.dn_less ? child_key : key_q;
			end
			mhpq_pkg::DP_PLACE: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd0_q <= mem[rd_addr0];
		rd1_q <= mem[rd_addr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd == mhpq_pkg::DP_LOAD && stat.start_up) begin
			count_q <= count_q + 1'b1;
		end else if (cmd == mhpq_pkg::DP_DN_INIT) begin
			count_q <= count_m1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			mhpq_pkg::DP_LOAD: begin
				key_q     <= in_key;
				idx_q     <= count_q[mhpq_pkg::IDX_W-1:0];
				res_key_q <= '0;
				if (in_mode == mhpq_pkg::MODE_EXTRACT) begin
					status_q <= empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_EXTRACTED;
				end else begin
					status_q <= full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_INSERTED;
				end
			end
			mhpq_pkg::DP_UP_STEP: begin
				if (stat.up_less) begin
					idx_q <= parent;
				end
			end
			mhpq_pkg::DP_DN_INIT: begin
				res_key_q <= rd0_q;
				key_q     <= rd1_q;
				idx_q     <= '0;
			end
			mhpq_pkg::DP_DN_STEP: begin
				if (stat.dn_less) begin
					idx_q <= use_r ? r_ch[mhpq_pkg::IDX_W-1:0] : l_ch[mhpq_pkg::IDX_W-1:0];
				end
			end
			mhpq_pkg::DP_OUT: begin
				out_status <= status_q;
				out_key    <= res_key_q;
				out_occ    <= mhpq_pkg::OCC_W'(count_q);
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/mhpq_ctrl.sv -----
// Controller state machine: sequences sift-up and sift-down steps and the output beat.
// Depends on mhpq_pkg; commands mhpq_datapath.
`timescale 1ns / 1ps

module mhpq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mhpq_pkg::dp_stat_t   stat,
	output mhpq_pkg::dp_cmd_t    cmd
);

	mhpq_pkg::ctl_state_t state_q, state_nx;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == mhpq_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhpq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == mhpq_pkg::S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = mhpq_pkg::DP_NOP;
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd = mhpq_pkg::DP_LOAD;
					if (stat.start_up) begin
						state_nx = mhpq_pkg::S_UP_RD;
					end else if (stat.start_dn) begin
						state_nx = mhpq_pkg::S_DN_RD0;
					end else begin
						state_nx = mhpq_pkg::S_FIN;
					end
				end
			end
			mhpq_pkg::S_UP_RD: begin
				if (stat.at_root) begin
					cmd      = mhpq_pkg::DP_PLACE;
					state_nx = mhpq_pkg::S_FIN;
				end else begin
					cmd      = mhpq_pkg::DP_UP_RD;
					state_nx = mhpq_pkg::S_UP_CMP;
				end
			end
			mhpq_pkg::S_UP_CMP: begin
				cmd      = mhpq_pkg::DP_UP_STEP;
				state_nx = stat.up_less ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_FIN;
			end
			mhpq_pkg::S_DN_RD0: begin
				cmd      = mhpq_pkg::DP_DN_RD0;
				state_nx = mhpq_pkg::S_DN_INIT;
			end
			mhpq_pkg::S_DN_INIT: begin
				cmd      = mhpq_pkg::DP_DN_INIT;
				state_nx = mhpq_pkg::S_DN_RD;
			end
			mhpq_pkg::S_DN_RD: begin
				// hole reached a leaf: drop the moving key there
				if (stat.no_child) begin
					cmd      = mhpq_pkg::DP_PLACE;
					state_nx = mhpq_pkg::S_FIN;
				end else begin
					cmd      = mhpq_pkg::DP_DN_RD;
					state_nx = mhpq_pkg::S_DN_CMP;
				end
			end
			mhpq_pkg::S_DN_CMP: begin
				cmd      = mhpq_pkg::DP_DN_STEP;
				state_nx = stat.dn_less ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_FIN;
			end
			mhpq_pkg::S_FIN: begin
				if (slot_free) begin
					cmd      = mhpq_pkg::DP_OUT;
					state_nx = mhpq_pkg::S_IDLE;
				end
			end
			default: state_nx = mhpq_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- hdl/min_heap_priority_queue_core.sv -----
// Min-heap priority queue core. One item at a time; the result beat sits in an
// output register, so the next item is taken while it waits.
// Insert: load, then a parent read and a compare per level climbed, ending at the root
// or where the key stops. Extract: load, read the last key, init, then a child read and a compare per level descended.
// Full/empty: load, then straight to the result. A result still waiting holds the next item in its final state.
// Reset (arst_n low, asynchronous) empties the queue; store contents are not cleared.
`timescale 1ns / 1ps

module min_heap_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] min_key, [39:32] occupancy
	output logic [1:0]  m_tuser    // [1:0] status
);

	mhpq_pkg::dp_cmd_t  cmd;
	mhpq_pkg::dp_stat_t stat;
	mhpq_pkg::key_t     out_key;
	logic [mhpq_pkg::OCC_W-1:0] out_occ;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mhpq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (s_tuser),
		.in_key     (s_tdata),
		.out_status (m_tuser),
		.out_key    (out_key),
		.out_occ    (out_occ)
	);

	assign m_tdata = {out_occ, out_key};

endmodule

// ----- bench/min_heap_priority_queue_core_test.sv -----
// Self-checking bench for min_heap_priority_queue_core: directed and random insert/extract
// traffic over the stream ports, checked beat by beat against a heap predictor.
// Depends on hdl/mhpq_pkg.sv and hdl/min_heap_priority_queue_core.sv.
`timescale 1ns / 1ps

module min_heap_priority_queue_core_test;

	localparam logic           MODE_INSERT   = ~mhpq_pkg::MODE_EXTRACT;
	localparam int             RANDOM_ITEMS  = 2000;
	localparam int             HOLD_CYCLES   = 300;
	localparam int             DRAIN_CYCLES  = 40;
	localparam int unsigned    CYCLE_LIMIT   = 1_500_000;
	localparam mhpq_pkg::key_t KEY_MIN       = 32'sh8000_0000;
	localparam mhpq_pkg::key_t KEY_MAX       = 32'sh7fff_ffff;

	typedef struct {
		mhpq_pkg::status_t status;
		mhpq_pkg::key_t    min_key;
		logic [7:0]        occupancy;
	} heap_result_t;

	// Keeps a software copy of the heap and the results it still owes.
	class heap_board;
		mhpq_pkg::key_t heap_keys [mhpq_pkg::CAPACITY];
		int unsigned    held;
		heap_result_t   owed_results [$];
		int             error_count;

		function new();
			held = 0;
			error_count = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			error_count++;
		endtask

		function void swap_keys(input int unsigned a, input int unsigned b);
			mhpq_pkg::key_t t;
			t = heap_keys[a];
			heap_keys[a] = heap_keys[b];
			heap_keys[b] = t;
		endfunction

		function void bubble_up(input int unsigned pos);
			int unsigned parent;
			while (pos > 0) begin
				parent = (pos - 1) / 2;
				if (!(heap_keys[pos] < heap_keys[parent]))
					break;
				swap_keys(pos, parent);
				pos = parent;
			end
		endfunction

		function void bubble_down(input int unsigned pos);
			int unsigned lc;
			int unsigned rc;
			int unsigned pick;
			forever begin
				lc = 2 * pos + 1;
				rc = lc + 1;
				if (lc >= held)
					break;
				pick = lc;
				// left child wins a tie
				if (rc < held && heap_keys[rc] < heap_keys[lc])
					pick = rc;
				if (!(heap_keys[pick] < heap_keys[pos]))
					break;
				swap_keys(pos, pick);
				pos = pick;
			end
		endfunction

		function void note_item(input logic mode, input mhpq_pkg::key_t key);
			heap_result_t r;
			r.min_key = '0;
			if (mode == MODE_INSERT) begin
				if (held >= mhpq_pkg::CAPACITY) begin
					r.status = mhpq_pkg::ST_FULL;
				end else begin
					heap_keys[held] = key;
					bubble_up(held);
					held++;
					r.status = mhpq_pkg::ST_INSERTED;
				end
			end else begin
				if (held == 0) begin
					r.status = mhpq_pkg::ST_EMPTY;
				end else begin
					r.min_key = heap_keys[0];
					held--;
					if (held > 0) begin
						heap_keys[0] = heap_keys[held];
						bubble_down(0);
					end
					r.status = mhpq_pkg::ST_EXTRACTED;
				end
			end
			r.occupancy = held[7:0];
			owed_results.push_back(r);
		endfunction

		task check_beat(input logic [1:0] status, input logic [31:0] min_key,
				input logic [7:0] occupancy);
			heap_result_t r;
			if (owed_results.size() == 0) begin
				report($sformatf("result beat with nothing outstanding (status %0d)", status));
			end else begin
				r = owed_results.pop_front();
				if (status !== r.status)
					report($sformatf("status %0d, want %0d", status, r.status));
				if (min_key !== r.min_key)
					report($sformatf("min_key %0d, want %0d", $signed(min_key), r.min_key));
				if (occupancy !== r.occupancy)
					report($sformatf("occupancy %0d, want %0d", occupancy, r.occupancy));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	heap_board board = new();

	int items_sent = 0;
	bit tx_free    = 1'b0;  // when set, sender never pauses
	bit rx_free    = 1'b0;  // when set, receiver starts no random stalls
	bit hold_req   = 1'b0;

	min_heap_priority_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** min_heap_priority_queue_core: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_beat(m_tuser, m_tdata[31:0], m_tdata[39:32]);
	end

	// Result side: random stalls, plus one long hold-off so the core backs up.
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_free && $urandom_range(0, 3) == 0)
					stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	function automatic mhpq_pkg::key_t pick_key();
		case ($urandom_range(0, 9))
			6, 7:    return mhpq_pkg::key_t'(int'($urandom_range(0, 16)) - 8);
			8: begin
				case ($urandom_range(0, 5))
					0:       return KEY_MIN;
					1:       return KEY_MAX;
					2:       return KEY_MIN + 1;
					3:       return KEY_MAX - 1;
					4:       return '0;
					default: return '1;
				endcase
			end
			default: return mhpq_pkg::key_t'($urandom);
		endcase
	endfunction

	// Leaves tvalid high when the next beat follows at once.
	task automatic send_item(input logic mode, input mhpq_pkg::key_t key);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_item(mode, key);
		items_sent++;
	endtask

	task automatic idle_sender();
		int n;
		if (tx_free)
			n = 0;
		else if ($urandom_range(0, 19) == 0)
			n = $urandom_range(10, 50);
		else
			n = $urandom_range(0, 2);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic do_insert(input mhpq_pkg::key_t key);
		send_item(MODE_INSERT, key);
		idle_sender();
	endtask

	task automatic do_extract();
		send_item(mhpq_pkg::MODE_EXTRACT, mhpq_pkg::key_t'($urandom));
		idle_sender();
	endtask

	initial begin
		int phase;
		int len;
		int ins_pct;
		int kind;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: underflow, extremes, ties, drain to empty
		do_extract();
		do_insert(KEY_MAX);
		do_insert(KEY_MIN);
		do_insert('0);
		do_insert('1);
		do_insert(1);
		do_insert('0);
		do_insert('1);
		do_insert(32'sh5555_5555);
		do_insert(mhpq_pkg::key_t'(32'haaaa_aaaa));
		repeat (4) do_extract();
		repeat (3) do_insert(7);
		repeat (8) do_extract();
		do_extract();

		// random phases: fill-heavy, balanced, drain-heavy
		phase = 0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			kind = (phase == 0) ? 0 : $urandom_range(0, 2);
			len = (phase == 0) ? 220 : $urandom_range(40, 250);
			ins_pct = (kind == 0) ? 92 : (kind == 1) ? 50 : 8;
			tx_free = ($urandom_range(0, 3) == 0);
			rx_free = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				hold_req = 1'b1;
				tx_free = 1'b1;
			end
			repeat (len) begin
				if ($urandom_range(0, 99) < ins_pct)
					do_insert(pick_key());
				else
					do_extract();
			end
			phase++;
		end
		s_tvalid <= 1'b0;
		rx_free = 1'b1;

		while (board.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.error_count == 0)
			$display("** min_heap_priority_queue_core: PASSED **");
		else
			$display("** min_heap_priority_queue_core: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mhpq_pkg.sv
hdl/mhpq_datapath.sv
hdl/mhpq_ctrl.sv
hdl/min_heap_priority_queue_core.sv
bench/min_heap_priority_queue_core_test.sv
